[sv/dsp_pkg.sv]
// Shared types and constants for the delay slot pool.
package dsp_pkg;

  // Width of a slot index in bits (index values 0 to 15).
  localparam int IDX_W = 4;

  localparam logic [2:0] TAG_NONE = 3'b111;
  localparam logic [7:0] USES_MAX = 8'hFF;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_CLAIM   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } dsp_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } dsp_state_t;

  // Request token that walks the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    dsp_req_t         kind;
    logic [63:0]      stamp;
    logic [2:0]       tag;
    logic [IDX_W-1:0] ptr;
    logic             hi_found;
    logic [IDX_W-1:0] hi_idx;
    logic             lo_found;
    logic [IDX_W-1:0] lo_idx;
    logic             hit;
    logic [7:0]       hit_uses;
  } dsp_carry_t;

  // Update broadcast from the controller to the cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             valid;
    logic [7:0]       uses;
    logic             stamp_en;
    logic [63:0]      stamp;
  } dsp_wr_t;

endpackage

[sv/dsp_cell.sv]
// One slot of the pool: its state and one stage of the request token row.
module dsp_cell
  import dsp_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dsp_carry_t carry_in,
  input  dsp_wr_t    wr,
  output dsp_carry_t carry_out
);

  logic        valid_r;
  logic [7:0]  uses_r;
  logic [63:0] stamp_r;
  dsp_carry_t  carry_r;
  dsp_carry_t  carry_nxt;
  logic        is_free;
  logic        is_hit;
  logic        wr_sel;

  assign is_free = (uses_r == 8'd0);
  assign wr_sel  = wr.en && (wr.idx == IDX_W'(CELL_IDX));

  always_comb begin
    is_hit = ((carry_in.kind == REQ_CLAIM) || (carry_in.kind == REQ_RELEASE)) &&
             !carry_in.tag[2] && (int'(carry_in.tag[1:0]) == CELL_IDX) &&
             valid_r && (stamp_r == carry_in.stamp);
  end

  // The scan keeps the first free slot at or after the pointer and, as a
  // fallback, the first free slot before it; the controller picks between them.
  always_comb begin
    carry_nxt = carry_in;
    if ((carry_in.kind == REQ_ALLOC) && is_free) begin
      if (CELL_IDX >= int'(carry_in.ptr)) begin
        if (!carry_in.hi_found) begin
          carry_nxt.hi_found = 1'b1;
          carry_nxt.hi_idx   = IDX_W'(CELL_IDX);
        end
      end else if (!carry_in.lo_found) begin
        carry_nxt.lo_found = 1'b1;
        carry_nxt.lo_idx   = IDX_W'(CELL_IDX);
      end
    end
    if (is_hit) begin
      carry_nxt.hit      = 1'b1;
      carry_nxt.hit_uses = uses_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.valid <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      uses_r  <= 8'd0;
      stamp_r <= 64'd0;
    end else if (wr_sel) begin
      valid_r <= wr.valid;
      uses_r  <= wr.uses;
      if (wr.stamp_en) begin
        stamp_r <= wr.stamp;
      end
    end
  end

  assign carry_out = carry_r;

endmodule

[sv/delay_slot_pool_core.sv]
// Top level of the delay slot pool: request controller and the row of slot cells.
//
// Requests enter on the in_ channel (valid/ready): in_req_type selects allocate,
// claim or release, in_stamp is the device time and in_slot_tag the slot held
// by the exposure. Every request gives exactly one result on the out_ channel.
// A transfer on the input launches a token that walks the row of NUM_SLOTS
// cells, one cell per cycle; each cell checks its own slot as the token passes.
// When the token leaves the last cell the controller updates the chosen slot
// and loads the result register, which raises out_valid. One request is in
// flight at a time: a new request is taken only once the token has left the
// cell row. The next request is taken in the same cycle that the pending
// result is transferred; while the receiver stalls, in_ready stays low.
// Reset clears all slots (invalid, zero uses, zero time), the search pointer
// and out_valid; the block is ready in the first cycle after reset.
module delay_slot_pool_core
  import dsp_pkg::*;
#(
  parameter int NUM_SLOTS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [63:0]       in_stamp,
  input  logic signed [2:0] in_slot_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [2:0] out_tag_out,
  output logic              out_prepare_cmd,
  output logic              out_invalidate_cmd,
  output logic [7:0]        out_count_out
);

  dsp_state_t       state_r;
  dsp_state_t       state_nxt;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] ptr_nxt;
  logic             out_valid_r;
  logic [2:0]       tag_r;
  logic [2:0]       tag_nxt;
  logic             prep_r;
  logic             prep_nxt;
  logic             inval_r;
  logic             inval_nxt;
  logic [7:0]       cnt_r;
  logic [7:0]       cnt_nxt;
  logic             in_fire;
  logic             commit;
  dsp_carry_t       head;
  dsp_carry_t       tail;
  dsp_wr_t          wr;
  dsp_carry_t       chain [NUM_SLOTS+1];
  logic             alloc_found;
  logic [IDX_W-1:0] alloc_idx;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       uses_nxt;

  assign in_fire = in_valid && in_ready;
  assign tail    = chain[NUM_SLOTS];

  always_comb begin
    head          = '0;
    head.valid    = in_fire;
    head.kind     = dsp_req_t'(in_req_type);
    head.stamp    = in_stamp;
    head.tag      = in_slot_tag;
    head.ptr      = ptr_r;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    dsp_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .carry_in  (chain[i]),
      .wr        (wr),
      .carry_out (chain[i+1])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = !out_valid_r || out_ready;
      ST_SCAN: commit   = tail.valid;
      default: in_ready = 1'b0;
    endcase
  end

  assign alloc_found = tail.hi_found || tail.lo_found;
  assign alloc_idx   = tail.hi_found ? tail.hi_idx : tail.lo_idx;
  assign hit_idx     = IDX_W'(tail.tag[1:0]);

  // Slot update and result for the token leaving the row.
  always_comb begin
    wr        = '0;
    wr.stamp  = tail.stamp;
    ptr_nxt   = ptr_r;
    tag_nxt   = TAG_NONE;
    prep_nxt  = 1'b0;
    inval_nxt = 1'b0;
    cnt_nxt   = 8'd0;
    uses_nxt  = 8'd0;
    unique case (tail.kind)
      REQ_ALLOC: begin
        if (alloc_found) begin
          wr.en       = commit;
          wr.idx      = alloc_idx;
          wr.valid    = 1'b1;
          wr.uses     = 8'd0;
          wr.stamp_en = 1'b1;
          tag_nxt     = 3'(alloc_idx);
          prep_nxt    = 1'b1;
          ptr_nxt     = (alloc_idx == IDX_W'(NUM_SLOTS - 1)) ? '0 : alloc_idx + IDX_W'(1);
        end
      end
      REQ_CLAIM: begin
        if (tail.hit) begin
          uses_nxt = (tail.hit_uses == USES_MAX) ? USES_MAX : tail.hit_uses + 8'd1;
          wr.en    = commit;
          wr.idx   = hit_idx;
          wr.valid = 1'b1;
          wr.uses  = uses_nxt;
          tag_nxt  = 3'(hit_idx);
          cnt_nxt  = uses_nxt;
        end
      end
      REQ_RELEASE: begin
        if (tail.hit) begin
          // A matched slot already at zero uses is invalidated without a decrement.
          uses_nxt  = (tail.hit_uses != 8'd0) ? tail.hit_uses - 8'd1 : 8'd0;
          wr.en     = commit;
          wr.idx    = hit_idx;
          wr.valid  = (uses_nxt != 8'd0);
          wr.uses   = uses_nxt;
          inval_nxt = (uses_nxt == 8'd0);
          cnt_nxt   = uses_nxt;
        end else begin
          tag_nxt = tail.tag;
        end
      end
      REQ_NONE: tag_nxt = TAG_NONE;
      default:  tag_nxt = TAG_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        ptr_r       <= ptr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      tag_r   <= tag_nxt;
      prep_r  <= prep_nxt;
      inval_r <= inval_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tag_out        = tag_r;
  assign out_prepare_cmd    = prep_r;
  assign out_invalidate_cmd = inval_r;
  assign out_count_out      = cnt_r;

  // A token in flight never coexists with a pending result.
  a_scan_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !out_valid_r)
    else $error("result pending while a request is in the cell row");

  // The token leaving the row always produces a result and frees the controller.
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("commit did not produce a result");

  // A transfer in launches exactly one token, which is seen at the row's end.
  a_token_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##NUM_SLOTS tail.valid)
    else $error("request token lost in the cell row");

  // A fresh allocation reports zero uses and never an invalidate.
  a_prepare_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && prep_r) |-> ((cnt_r == 8'd0) && !inval_r))
    else $error("prepare result with nonzero count or invalidate");

endmodule

[dv/delay_slot_pool_core_tb.sv]
// Self-checking testbench for the delay slot pool: directed table, saturation run, random requests.
module delay_slot_pool_core_tb;
  import dsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 3;
  localparam int RANDOM_ITEMS = 220;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0] tag;
    logic       prep;
    logic       inval;
    logic [7:0] cnt;
  } pool_result_t;

  typedef struct {
    dsp_req_t     kind;
    logic [63:0]  stamp;
    logic [2:0]   tag;
    bit           typed;
    pool_result_t want;
  } pool_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_req_type = REQ_ALLOC;
  logic [63:0]       in_stamp = '0;
  logic signed [2:0] in_slot_tag = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [2:0] out_tag_out;
  logic              out_prepare_cmd;
  logic              out_invalidate_cmd;
  logic [7:0]        out_count_out;

  // Shadow copy of the pool, advanced once per accepted request.
  logic        slot_live [NUM_SLOTS];
  logic [7:0]  slot_use_count [NUM_SLOTS];
  logic [63:0] slot_time [NUM_SLOTS];
  int          scan_ptr;

  pool_result_t pending_results[$];
  pool_row_t    directed_rows[$];

  int          mismatches = 0;
  int          results_seen = 0;
  int          n_alloc = 0, n_claim = 0, n_release = 0, n_other = 0;
  int          n_prepare = 0, n_invalidate = 0, n_saturated = 0;
  bit          quiet_mode = 1'b0;
  int          rx_hold = 0;
  int unsigned cycle_count = 0;

  delay_slot_pool_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_stamp          (in_stamp),
    .in_slot_tag       (in_slot_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tag_out       (out_tag_out),
    .out_prepare_cmd   (out_prepare_cmd),
    .out_invalidate_cmd(out_invalidate_cmd),
    .out_count_out     (out_count_out)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("delay_slot_pool_core: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (quiet_mode || sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pool_result_t pool_apply(dsp_req_t kind, logic [63:0] t, logic [2:0] tg);
    pool_result_t r;
    int p, k, i;
    bit found, hit;
    r = '{tag: TAG_NONE, prep: 1'b0, inval: 1'b0, cnt: 8'd0};
    hit = 1'b0;
    k = int'(tg);
    if (!tg[2] && k < NUM_SLOTS) begin
      if (slot_live[k] && slot_time[k] == t) hit = 1'b1;
    end
    case (kind)
      REQ_ALLOC: begin
        found = 1'b0;
        p = scan_ptr % NUM_SLOTS;
        for (i = 0; i < NUM_SLOTS && !found; i++) begin
          k = p;
          p = (p + 1) % NUM_SLOTS;
          if (slot_use_count[k] == 8'd0) begin
            found = 1'b1;
            slot_time[k] = t;
            slot_live[k] = 1'b1;
            r.tag = 3'(k);
            r.prep = 1'b1;
          end
        end
        scan_ptr = p;
      end
      REQ_CLAIM: begin
        if (hit) begin
          if (slot_use_count[k] != USES_MAX) slot_use_count[k]++;
          r.tag = tg;
          r.cnt = slot_use_count[k];
        end
      end
      REQ_RELEASE: begin
        if (hit) begin
          if (slot_use_count[k] != 8'd0) slot_use_count[k]--;
          // A matched release at zero still invalidates the slot.
          if (slot_use_count[k] == 8'd0) begin
            slot_live[k] = 1'b0;
            r.inval = 1'b1;
          end
          r.cnt = slot_use_count[k];
        end else begin
          r.tag = tg;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue_request(dsp_req_t kind, logic [63:0] t, logic [2:0] tg,
                               bit typed, pool_result_t want);
    pool_result_t r;
    int gap;
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_stamp <= t;
    in_slot_tag <= tg;
    do @(posedge clk); while (!in_ready);
    r = pool_apply(kind, t, tg);
    case (kind)
      REQ_ALLOC:   n_alloc++;
      REQ_CLAIM:   n_claim++;
      REQ_RELEASE: n_release++;
      default:     n_other++;
    endcase
    if (r.prep) n_prepare++;
    if (r.inval) n_invalidate++;
    if (kind == REQ_CLAIM && r.cnt == USES_MAX) n_saturated++;
    pending_results.push_back(typed ? want : r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic pool_row_t mk_row(dsp_req_t kind, logic [63:0] t, logic [2:0] tg, bit typed,
                                       logic [2:0] e_tag, logic e_prep, logic e_inval,
                                       logic [7:0] e_cnt);
    pool_row_t row;
    row.kind = kind;
    row.stamp = t;
    row.tag = tg;
    row.typed = typed;
    row.want = '{tag: e_tag, prep: e_prep, inval: e_inval, cnt: e_cnt};
    return row;
  endfunction

  // Random requests lean on the shadow pool so most claims and releases carry the addressed slot's stamp.
  task automatic random_request();
    dsp_req_t kind;
    logic [63:0] t;
    logic [2:0] tg;
    int sel, k;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, NUM_SLOTS - 1);
    t = {$urandom, $urandom};
    tg = 3'(k);
    if (sel < 30) begin
      kind = REQ_ALLOC;
      if ($urandom_range(0, 3) == 0) t = 64'($urandom_range(0, 3));
    end else if (sel < 60) begin
      kind = REQ_CLAIM;
      if ($urandom_range(0, 9) != 0) t = slot_time[k];
    end else if (sel < 88) begin
      kind = REQ_RELEASE;
      if ($urandom_range(0, 9) != 0) t = slot_time[k];
    end else begin
      kind = dsp_req_t'($urandom_range(0, 3));
      tg = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0) t = slot_time[k];
    end
    issue_request(kind, t, tg, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      rx_hold = pick_gap();
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pool_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_tag_out, out_prepare_cmd, out_invalidate_cmd, out_count_out};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tag %0d prepare %0b invalidate %0b count %0d",
                   $signed(got.tag), got.prep, got.inval, got.cnt);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected tag %0d prep %0b inval %0b count %0d",
                     results_seen, $signed(want.tag), want.prep, want.inval, want.cnt);
            $display("result %0d: got tag %0d prep %0b inval %0b count %0d",
                     results_seen, $signed(got.tag), got.prep, got.inval, got.cnt);
          end
        end
      end
    end
  end

  initial begin
    pool_row_t row;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_use_count[i] = 8'd0;
      slot_time[i] = '0;
    end
    scan_ptr = 0;

    // Typed rows hold results that follow directly from the pool contents at that point.
    directed_rows.push_back(mk_row(REQ_CLAIM, 64'd0, 3'd0, 1'b1, TAG_NONE, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_RELEASE, 64'd0, 3'd0, 1'b1, 3'd0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_NONE, '1, 3'b111, 1'b1, TAG_NONE, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_ALLOC, '1, 3'd0, 1'b1, 3'd0, 1'b1, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_CLAIM, '1, 3'd0, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 64'd0, 3'd0, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 64'd5, 3'd0, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 64'd6, 3'd0, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_CLAIM, 64'd6, 3'd1, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_CLAIM, 64'd5, 3'd2, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_CLAIM, 64'd4, 3'd2, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 64'd7, 3'd0, 1'b1, TAG_NONE, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_CLAIM, 64'd5, 3'd3, 1'b1, TAG_NONE, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_CLAIM, '1, 3'b111, 1'b1, TAG_NONE, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_RELEASE, 64'd5, 3'b110, 1'b1, 3'b110, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_RELEASE, 64'd5, 3'd3, 1'b1, 3'd3, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_NONE, 64'd6, 3'd1, 1'b1, TAG_NONE, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_RELEASE, 64'd6, 3'd1, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_RELEASE, 64'd6, 3'd1, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 64'd9, 3'd0, 1'b0, '0, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(mk_row(REQ_RELEASE, 64'd9, 3'd1, 1'b0, '0, 1'b0, 1'b0, 8'd0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue_request(row.kind, row.stamp, row.tag, row.typed, row.want);
    end
    in_valid <= 1'b0;
    drain_results();

    // Slot 0 still holds the all-ones time with one use: drive it past saturation and a few
    // steps back. It stays claimed through the random part that follows.
    for (int i = 0; i < 256; i++) issue_request(REQ_CLAIM, '1, 3'd0, 1'b0, '0);
    for (int i = 0; i < 4; i++) issue_request(REQ_RELEASE, '1, 3'd0, 1'b0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_mode = (i >= 80 && i < 120);
      if (i == 160) begin
        in_valid <= 1'b0;
        drain_results();
      end
      random_request();
    end
    quiet_mode = 1'b0;
    in_valid <= 1'b0;

    drain_results();
    repeat (NUM_SLOTS + 8) @(posedge clk);

    $display("requests: %0d allocate, %0d claim, %0d release, %0d unknown; %0d results checked",
             n_alloc, n_claim, n_release, n_other, results_seen);
    $display("slots prepared %0d, invalidated %0d, claims at the use ceiling %0d",
             n_prepare, n_invalidate, n_saturated);
    if (mismatches == 0) begin
      $display("delay_slot_pool_core: match");
    end else begin
      $display("delay_slot_pool_core: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/dsp_pkg.sv
sv/dsp_cell.sv
sv/delay_slot_pool_core.sv
dv/delay_slot_pool_core_tb.sv
